// ===== design/pos_pkg.sv =====
`default_nettype none

package pos_pkg;

   // field widths
   localparam int OPCODE_WIDTH    = 2;
   localparam int TIME_WIDTH      = 32;
   localparam int RESULT_WIDTH    = 32;
   localparam int CSR_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   // shared divider geometry: the dividend is sized for count*100, the divisor for ppm*interval
   localparam int DIV_NUM_WIDTH   = RESULT_WIDTH + 7;
   localparam int DIV_DEN_WIDTH   = CSR_WIDTH + TIME_WIDTH;
   localparam int DIV_CNT_WIDTH   = $clog2(DIV_NUM_WIDTH);

   localparam logic [CSR_WIDTH-1:0] DEFAULT_PULSES_PER_METER_VAL = CSR_WIDTH'(100);
   localparam logic [CSR_WIDTH-1:0] MIN_GAP_RESET = CSR_WIDTH'(1000);

   localparam logic [DIV_NUM_WIDTH-1:0] CM_PER_METRE   = DIV_NUM_WIDTH'(100);
   localparam logic [DIV_NUM_WIDTH-1:0] SPEED_NUMERATOR = DIV_NUM_WIDTH'(1000000000);

   // operation codes
   localparam logic [OPCODE_WIDTH-1:0] OP_PULSE  = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_REPORT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PPM = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP = 1'd1;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic [TIME_WIDTH-1:0]   timestamp_us;
   } req_type;

   typedef struct packed {
      logic                    pulse_accepted;
      logic [RESULT_WIDTH-1:0] pulse_total;
      logic [RESULT_WIDTH-1:0] distance_cm;
      logic [RESULT_WIDTH-1:0] speed_mm_per_s;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic calc_prod;
      logic div_start;
      logic div_sel_speed;
      logic cap_dist;
      logic cap_speed;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic interval_zero;
   } status_type;

endpackage

`default_nettype wire

// ===== design/pos_div.sv =====
`default_nettype none

module pos_div import pos_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [DIV_NUM_WIDTH-1:0] dividend,
   input  wire logic [DIV_DEN_WIDTH-1:0] divisor,
   output logic                          done,
   output logic [DIV_NUM_WIDTH-1:0]      quotient
);

   logic [DIV_DEN_WIDTH:0]   rem_ff, rem_in;
   logic [DIV_NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_DEN_WIDTH-1:0] den_ff;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff;
   logic                     run_ff;
   logic                     done_ff;
   logic [DIV_DEN_WIDTH:0]   trial;
   logic                     fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff[DIV_DEN_WIDTH-1:0], quo_ff[DIV_NUM_WIDTH-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? trial - {1'b0, den_ff} : trial;
      quo_in = {quo_ff[DIV_NUM_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= DIV_CNT_WIDTH'(DIV_NUM_WIDTH - 1);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // payload: load operands on start, iterate while running
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/pos_dpath.sv =====
`default_nettype none

module pos_dpath import pos_pkg::*; #(
   parameter logic [CSR_WIDTH-1:0] DEFAULT_PULSES_PER_METER = DEFAULT_PULSES_PER_METER_VAL
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire req_type                    req_data,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_WIDTH-1:0]       csr_wdata,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   output rsp_type                         rsp_data
);

   logic [CSR_WIDTH-1:0]     ppm_ff, gap_ff;
   logic [TIME_WIDTH-1:0]    count_ff, count_in;
   logic [TIME_WIDTH-1:0]    prev_ff, prev_in;
   logic [TIME_WIDTH-1:0]    interval_ff, interval_in;
   logic                     acc_ff, acc_in;
   logic [DIV_DEN_WIDTH-1:0] prod_ff;
   logic [DIV_NUM_WIDTH-1:0] dist_num_ff;
   logic [RESULT_WIDTH-1:0]  dist_ff, speed_ff;
   rsp_type                  rsp_ff;

   logic [CSR_WIDTH-1:0]     ppm_eff;
   logic [TIME_WIDTH-1:0]    dt;
   logic                     have_prev;
   logic                     take;
   logic [DIV_NUM_WIDTH-1:0] div_num;
   logic [DIV_DEN_WIDTH-1:0] div_den;
   logic                     div_done;
   logic [DIV_NUM_WIDTH-1:0] div_quo;
   logic [RESULT_WIDTH-1:0]  div_sat;

   assign ppm_eff = (ppm_ff == '0) ? DEFAULT_PULSES_PER_METER : ppm_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ppm_ff <= '0;
         gap_ff <= MIN_GAP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PPM: ppm_ff <= csr_wdata;
            CSR_GAP: gap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // odometer state update for one item
   always_comb begin
      dt          = req_data.timestamp_us - prev_ff;
      have_prev   = prev_ff != '0;
      take        = !(have_prev && (dt < {{(TIME_WIDTH-CSR_WIDTH){1'b0}}, gap_ff}));
      count_in    = count_ff;
      prev_in     = prev_ff;
      interval_in = interval_ff;
      acc_in      = 1'b0;
      case (req_data.opcode)
         OP_PULSE: begin
            if (take) begin
               if (have_prev) interval_in = dt;
               prev_in  = req_data.timestamp_us;
               if (count_ff != '1) count_in = count_ff + 1'b1;
               acc_in   = 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in    = '0;
            prev_in     = '0;
            interval_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         prev_ff     <= '0;
         interval_ff <= '0;
      end else if (cmd.load_item) begin
         count_ff    <= count_in;
         prev_ff     <= prev_in;
         interval_ff <= interval_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) acc_ff <= acc_in;
      if (cmd.calc_prod) begin
         prod_ff     <= {{CSR_WIDTH{1'b0}}, interval_ff} *
                        {{TIME_WIDTH{1'b0}}, ppm_eff};
         dist_num_ff <= {{(DIV_NUM_WIDTH-TIME_WIDTH){1'b0}}, count_ff} * CM_PER_METRE;
         speed_ff    <= '0;
      end
      if (cmd.cap_dist)  dist_ff  <= div_sat;
      if (cmd.cap_speed) speed_ff <= div_sat;
      if (cmd.load_out) begin
         rsp_ff.pulse_accepted <= acc_ff;
         rsp_ff.pulse_total    <= count_ff;
         rsp_ff.distance_cm    <= dist_ff;
         rsp_ff.speed_mm_per_s <= speed_ff;
      end
   end

   // shared divider operand selection
   assign div_num = cmd.div_sel_speed ? SPEED_NUMERATOR : dist_num_ff;
   assign div_den = cmd.div_sel_speed ? prod_ff
                                      : {{TIME_WIDTH{1'b0}}, ppm_eff};

   pos_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // saturate the quotient to the result width
   assign div_sat = (|div_quo[DIV_NUM_WIDTH-1:RESULT_WIDTH]) ? '1
                                                             : div_quo[RESULT_WIDTH-1:0];

   assign status.div_done      = div_done;
   assign status.interval_zero = interval_ff == '0;
   assign rsp_data             = rsp_ff;

endmodule

`default_nettype wire

// ===== design/pos_ctrl.sv =====
`default_nettype none

module pos_ctrl import pos_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROD,
      S_DIST_GO,
      S_DIST_RUN,
      S_SPD_GO,
      S_SPD_RUN,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.div_sel_speed = (state_ff == S_SPD_GO) || (state_ff == S_SPD_RUN);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_PROD;
            end
         end
         S_PROD: begin
            cmd.calc_prod = 1'b1;
            state_in      = S_DIST_GO;
         end
         S_DIST_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIST_RUN;
         end
         S_DIST_RUN: begin
            if (status.div_done) begin
               cmd.cap_dist = 1'b1;
               state_in     = S_SPD_GO;
            end
         end
         S_SPD_GO: begin
            if (status.interval_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_SPD_RUN;
            end
         end
         S_SPD_RUN: begin
            if (status.div_done) begin
               cmd.cap_speed = 1'b1;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/pulse_odometer_speed.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  opcode, timestamp_us
// rsp_      out        rsp_valid/rsp_stall  pulse_accepted, pulse_total, distance_cm, speed
// csr_      in         csr_write            csr_index, csr_wdata
//
// Each item makes one pass of the shared one-bit-a-cycle divider (39 steps) for
// the distance and, unless the stored interval is zero, a second for the speed;
// no new item is taken before the one in work is loaded into the output register.
// Reset is synchronous and returns the counters, configuration registers and control state to their reset values.
// A result waits in the output register under rsp_stall; the next item is
// taken meanwhile and only its final load waits for that register to drain.
`default_nettype none

module pulse_odometer_speed import pos_pkg::*; #(
   parameter logic [CSR_WIDTH-1:0] DEFAULT_PULSES_PER_METER = DEFAULT_PULSES_PER_METER_VAL
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_WIDTH-1:0]       csr_wdata
);

   cmd_type    cmd;
   status_type status;

   pos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pos_dpath #(
      .DEFAULT_PULSES_PER_METER (DEFAULT_PULSES_PER_METER)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // an accepted beat makes the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after accepting a beat");

   // a new result only appears after the block has been working
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without work");

   // a counted pulse always leaves a non-zero total
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pulse_accepted) |-> (rsp_data.pulse_total != '0))
      else $error("accepted pulse with zero total");
`endif

endmodule

`default_nettype wire
